// ----- hdl/crsf_rc_channel_frame_decoder_assert.svh -----
// Assertion macros shared by the CRSF decoder modules.
// Each use expects signal aclk, and CRSF_ASSERT also aresetn, in the enclosing module.
`ifndef CRSF_RC_CHANNEL_FRAME_DECODER_ASSERT_SVH
`define CRSF_RC_CHANNEL_FRAME_DECODER_ASSERT_SVH

// Checked only while out of reset.
`define CRSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define CRSF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hdl/crsf_pkg.sv -----
// Shared types and constants of the CRSF RC channel frame decoder.
// No dependencies; used by every module of the block.
package crsf_pkg;

    localparam int MAX_FRAME_LENGTH     = 62;
    localparam int STORE_DEPTH          = 22;
    localparam int CHANNEL_COUNT        = 16;
    localparam int CHANNEL_BITS         = 11;
    localparam int CHANNEL_FRAME_LENGTH = 24;
    localparam int PAYLOAD_W            = STORE_DEPTH * 8;
    localparam int LEN_W                = $clog2(MAX_FRAME_LENGTH + 1);
    localparam int STORE_AW             = $clog2(STORE_DEPTH);
    localparam int Q_DEPTH              = 2;
    localparam int Q_AW                 = $clog2(Q_DEPTH);
    localparam int Q_CW                 = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] MIN_LEN_BYTE = 8'd2;
    localparam logic [7:0] MAX_LEN_BYTE = 8'(MAX_FRAME_LENGTH);

    localparam logic [7:0] SYNC_RESET = 8'd200;
    localparam logic [7:0] TYPE_RESET = 8'd22;
    localparam logic [7:0] POLY_RESET = 8'hD5;

    localparam logic [3:0] LAST_CHANNEL_IDX = 4'(CHANNEL_COUNT - 1);

    typedef enum logic [1:0] {
        REG_SYNC_VALUE         = 2'd0,
        REG_CHANNEL_FRAME_TYPE = 2'd1,
        REG_CRC_POLYNOMIAL     = 2'd2
    } cfg_idx_t;

    typedef logic [LEN_W-1:0]     len_t;
    typedef logic [PAYLOAD_W-1:0] payload_t;

    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] channel_frame_type;
        logic [7:0] crc_polynomial;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       line_idle;
    } in_t;

    typedef struct packed {
        logic [3:0]  channel_index;
        logic [10:0] channel_value;
        logic        last_channel;
    } out_t;

    localparam len_t CH_FRAME_LEN = len_t'(CHANNEL_FRAME_LENGTH);

endpackage

// ----- hdl/crsf_frm.sv -----
// Front end: frame parser with running CRC-8 and payload capture.
// Pushes the payload of each good RC channel frame into the queue; uses crsf_pkg.
`include "crsf_rc_channel_frame_decoder_assert.svh"

module crsf_frm (
    input  logic                aclk,
    input  logic                aresetn,
    input  crsf_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  crsf_pkg::in_t       in_data,
    output logic                push,
    output crsf_pkg::payload_t  push_data,
    input  logic                q_full
);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'b001,
        PH_LENGTH = 3'b010,
        PH_BODY   = 3'b100
    } phase_t;

    phase_t             phase_reg, phase_next;
    crsf_pkg::len_t     len_reg, len_next;
    crsf_pkg::len_t     pos_reg, pos_next;
    logic [7:0]         crc_reg, crc_next;
    logic [7:0]         type_reg, type_next;
    logic [7:0]         store_reg [crsf_pkg::STORE_DEPTH];
    logic               store_we;
    crsf_pkg::len_t     store_off;
    logic               fire;
    logic [7:0]         b;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    assign in_ready  = !q_full;
    assign fire      = in_valid && in_ready;
    assign b         = in_data.rx_byte;
    assign store_off = pos_reg - crsf_pkg::len_t'(1);

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        type_next  = type_reg;
        store_we   = 1'b0;
        push       = 1'b0;
        if (fire) begin
            if (in_data.line_idle) begin
                phase_next = PH_HUNT;
            end else begin
                case (phase_reg)
                    PH_LENGTH: begin
                        if (b < crsf_pkg::MIN_LEN_BYTE || b > crsf_pkg::MAX_LEN_BYTE) begin
                            phase_next = PH_HUNT;
                        end else begin
                            len_next   = crsf_pkg::len_t'(b);
                            pos_next   = '0;
                            crc_next   = '0;
                            phase_next = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if ({1'b0, pos_reg} + 1'b1 >= {1'b0, len_reg}) begin
                            // CRC byte: close the frame
                            push = (b == crc_reg) && (type_reg == cfg.channel_frame_type)
                                   && (len_reg == crsf_pkg::CH_FRAME_LEN);
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                        end else begin
                            if (pos_reg == '0) begin
                                type_next = b;
                            end else begin
                                store_we = store_off < crsf_pkg::len_t'(crsf_pkg::STORE_DEPTH);
                            end
                            crc_next = crc8_step(crc_reg, b, cfg.crc_polynomial);
                            pos_next = pos_reg + crsf_pkg::len_t'(1);
                        end
                    end
                    default: begin
                        phase_next = (b == cfg.sync_value) ? PH_LENGTH : PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            len_reg   <= '0;
            pos_reg   <= '0;
            crc_reg   <= '0;
            type_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            type_reg  <= type_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[store_off[crsf_pkg::STORE_AW-1:0]] <= b;
        end
    end

    // byte 0 lands in the low bits of the payload word
    always_comb begin
        for (int i = 0; i < crsf_pkg::STORE_DEPTH; i++) begin
            push_data[i*8 +: 8] = store_reg[i];
        end
    end

    `CRSF_ASSERT(a_push_frame, push |-> (phase_reg == PH_BODY) && (len_reg == crsf_pkg::CH_FRAME_LEN) && !in_data.line_idle, "payload pushed outside a channel frame end")
    `CRSF_ASSERT(a_push_room, push |-> !q_full, "payload pushed into a full queue")

endmodule

// ----- hdl/crsf_q.sv -----
// Two-entry payload queue between the frame parser and the channel unpacker.
// Depth and width come from crsf_pkg.
module crsf_q (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  crsf_pkg::payload_t  push_data,
    output logic                full,
    input  logic                pop,
    output crsf_pkg::payload_t  pop_data,
    output logic                empty
);

    crsf_pkg::payload_t          mem_reg [crsf_pkg::Q_DEPTH];
    logic [crsf_pkg::Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [crsf_pkg::Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [crsf_pkg::Q_CW-1:0]   count_reg, count_next;

    localparam logic [crsf_pkg::Q_AW-1:0] PTR_LAST = crsf_pkg::Q_AW'(crsf_pkg::Q_DEPTH - 1);
    localparam logic [crsf_pkg::Q_CW-1:0] CNT_FULL = crsf_pkg::Q_CW'(crsf_pkg::Q_DEPTH);

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/crsf_chn.sv -----
// Back end: unpacks one queued payload into sixteen 11-bit channels.
// Drives the output register of the result channel; uses crsf_pkg.
`include "crsf_rc_channel_frame_decoder_assert.svh"

module crsf_chn (
    input  logic                aclk,
    input  logic                aresetn,
    output logic                pop,
    input  crsf_pkg::payload_t  pop_data,
    input  logic                empty,
    output logic                m_valid,
    input  logic                m_ready,
    output crsf_pkg::out_t      m_data
);

    crsf_pkg::payload_t  work_reg, work_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                m_valid_reg, m_valid_next;
    crsf_pkg::out_t      m_data_reg, m_data_next;
    logic                load;

    assign pop     = !busy_reg && !empty;
    assign load    = busy_reg && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        work_next    = work_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (pop) begin
            work_next = pop_data;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (load) begin
            // take the low channel, then shift the next one down
            m_valid_next               = 1'b1;
            m_data_next.channel_index  = cnt_reg;
            m_data_next.channel_value  = work_reg[crsf_pkg::CHANNEL_BITS-1:0];
            m_data_next.last_channel   = (cnt_reg == crsf_pkg::LAST_CHANNEL_IDX);
            work_next = work_reg >> crsf_pkg::CHANNEL_BITS;
            cnt_next  = cnt_reg + 4'd1;
            if (cnt_reg == crsf_pkg::LAST_CHANNEL_IDX) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg   <= work_next;
        m_data_reg <= m_data_next;
    end

    `CRSF_ASSERT(a_burst_cont, (m_valid_reg && m_ready && !m_data_reg.last_channel) |=> m_valid_reg && (m_data_reg.channel_index == $past(m_data_reg.channel_index) + 4'd1), "channel burst broke before the last channel")
    `CRSF_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_valid_reg && !busy_reg, "result valid right after reset")

endmodule

// ----- hdl/crsf_rc_channel_frame_decoder.sv -----
// CRSF RC channel frame decoder, top level.
// Holds the configuration registers and joins parser, queue and unpacker.
//
// Usage:
//   s_valid/s_ready/s_data carry one received byte or an idle-line marker per
//   transaction (s_data.line_idle set = marker). The parser takes one byte per
//   cycle; s_ready drops only while both queue entries hold decoded frames.
//   m_valid/m_ready/m_data give one channel per transaction: index, 11-bit
//   value and a flag on channel 15. A good frame yields exactly 16 of them.
//   After the CRC byte's transaction the payload is written to the queue, loaded
//   into the unpacker and its first channel registered at the output; the rest
//   follow one per cycle while m_ready stays high.
//   A stalled receiver holds the current channel in the output register; the
//   parser keeps taking bytes until the two-entry queue is full.
//   cfg_wr_en/cfg_index/cfg_data write sync_value (0), channel_frame_type (1)
//   and crc_polynomial (2); other indexes are ignored. Write only when idle.
//   Reset (aresetn low, synchronous) restores the register defaults, returns
//   the parser to sync hunting and empties the queue and output register.
module crsf_rc_channel_frame_decoder (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_data,
    input  logic            s_valid,
    output logic            s_ready,
    input  crsf_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output crsf_pkg::out_t  m_data
);

    crsf_pkg::cfg_t      cfg_reg, cfg_next;
    logic                push, pop, q_full, q_empty;
    crsf_pkg::payload_t  push_data, pop_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                crsf_pkg::REG_SYNC_VALUE:         cfg_next.sync_value         = cfg_data;
                crsf_pkg::REG_CHANNEL_FRAME_TYPE: cfg_next.channel_frame_type = cfg_data;
                crsf_pkg::REG_CRC_POLYNOMIAL:     cfg_next.crc_polynomial     = cfg_data;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_value         <= crsf_pkg::SYNC_RESET;
            cfg_reg.channel_frame_type <= crsf_pkg::TYPE_RESET;
            cfg_reg.crc_polynomial     <= crsf_pkg::POLY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    crsf_frm u_frm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    crsf_q u_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    crsf_chn u_chn (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (q_empty),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ----- verif/tb_crsf_rc_channel_frame_decoder.sv -----
`timescale 1ns / 1ps
// Testbench for crsf_rc_channel_frame_decoder: queued byte driver, channel monitor, scoreboard.
// Depends on crsf_pkg and the decoder RTL only; self-checking against a built-in frame parser.
module tb_crsf_rc_channel_frame_decoder;

    localparam int RX_HOLD_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES     = 24;
    localparam int ITEMS_PER_PHASE  = 12;

    typedef enum logic [1:0] {HUNT_SYNC, WAIT_LENGTH, IN_BODY} hunt_state_t;
    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_CHECKER} payload_fill_t;
    typedef enum {RX_STEADY, RX_COIN, RX_PATTERN} rx_mode_t;

    logic           aclk;
    logic           aresetn   = 1'b0;
    logic           cfg_wr_en = 1'b0;
    logic [1:0]     cfg_index = '0;
    logic [7:0]     cfg_data  = '0;
    logic           s_valid   = 1'b0;
    logic           s_ready;
    crsf_pkg::in_t  s_data    = '0;
    logic           m_valid;
    logic           m_ready   = 1'b0;
    crsf_pkg::out_t m_data;

    crsf_rc_channel_frame_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Register copies, shared by the stimulus builder and the parser model
    logic [7:0] cfg_sync = crsf_pkg::SYNC_RESET;
    logic [7:0] cfg_type = crsf_pkg::TYPE_RESET;
    logic [7:0] cfg_poly = crsf_pkg::POLY_RESET;

    // Parser model state
    hunt_state_t hunt_state = HUNT_SYNC;
    logic [7:0]  body_len   = '0;
    logic [7:0]  body_pos   = '0;
    logic [7:0]  body_crc   = '0;
    logic [7:0]  body_type  = '0;
    logic [7:0]  body_bytes [crsf_pkg::STORE_DEPTH];

    crsf_pkg::in_t  pending_items[$];
    crsf_pkg::out_t expected_channels[$];
    crsf_pkg::out_t next_channel;
    int   items_queued   = 0;
    int   items_accepted = 0;
    int   mismatch_count = 0;
    int   quiet_cycles   = 0;

    int       burst_left = 0;
    int       gap_left   = 0;
    int       rx_seg_left = 0;
    int       rx_tick    = 0;
    rx_mode_t rx_mode    = RX_STEADY;
    int       hold_requests = 0;
    int       holds_done    = 0;
    int       hold_count    = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] r;
        r = crc ^ data;
        repeat (8) r = r[7] ? ((r << 1) ^ poly) : (r << 1);
        return r;
    endfunction

    // Advance the parser model by one accepted transaction and queue any channels it yields
    task automatic decode_byte(input crsf_pkg::in_t item);
        logic [crsf_pkg::PAYLOAD_W-1:0] packed_bytes;
        crsf_pkg::out_t                 ch_out;
        bit                             good;
        if (item.line_idle) begin
            hunt_state = HUNT_SYNC;
            return;
        end
        case (hunt_state)
            WAIT_LENGTH: begin
                if (item.rx_byte < crsf_pkg::MIN_LEN_BYTE ||
                    item.rx_byte > crsf_pkg::MAX_LEN_BYTE) begin
                    hunt_state = HUNT_SYNC;
                end else begin
                    body_len   = item.rx_byte;
                    body_pos   = '0;
                    body_crc   = '0;
                    hunt_state = IN_BODY;
                end
            end
            IN_BODY: begin
                if (int'(body_pos) + 1 >= int'(body_len)) begin
                    good = (item.rx_byte == body_crc) && (body_type == cfg_type) &&
                           (int'(body_len) == crsf_pkg::CHANNEL_FRAME_LENGTH);
                    hunt_state = HUNT_SYNC;
                    body_pos   = '0;
                    if (good) begin
                        for (int i = 0; i < crsf_pkg::STORE_DEPTH; i++)
                            packed_bytes[i*8 +: 8] = body_bytes[i];
                        for (int ch = 0; ch < crsf_pkg::CHANNEL_COUNT; ch++) begin
                            ch_out.channel_index = 4'(ch);
                            ch_out.channel_value =
                                packed_bytes[ch*crsf_pkg::CHANNEL_BITS +: crsf_pkg::CHANNEL_BITS];
                            ch_out.last_channel  = (ch == crsf_pkg::CHANNEL_COUNT - 1);
                            expected_channels.push_back(ch_out);
                        end
                    end
                end else begin
                    if (body_pos == 0)
                        body_type = item.rx_byte;
                    else if (int'(body_pos) - 1 < crsf_pkg::STORE_DEPTH)
                        body_bytes[body_pos - 1] = item.rx_byte;
                    body_crc = crc8_next(body_crc, item.rx_byte, cfg_poly);
                    body_pos = body_pos + 1;
                end
            end
            default: hunt_state = (item.rx_byte == cfg_sync) ? WAIT_LENGTH : HUNT_SYNC;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic push_item(input logic [7:0] data, input logic idle);
        crsf_pkg::in_t item;
        item.rx_byte   = data;
        item.line_idle = idle;
        pending_items.push_back(item);
        items_queued++;
    endtask

    task automatic push_idle();
        push_item(8'($urandom), 1'b1);
    endtask

    task automatic push_frame(input int len, input logic [7:0] ftype, input payload_fill_t fill,
                              input bit corrupt_crc);
        logic [7:0] crc;
        logic [7:0] data;
        push_item(cfg_sync, 1'b0);
        push_item(8'(len), 1'b0);
        push_item(ftype, 1'b0);
        crc = crc8_next(8'h00, ftype, cfg_poly);
        for (int i = 0; i < len - 2; i++) begin
            case (fill)
                FILL_ONES:    data = 8'hFF;
                FILL_ZEROS:   data = 8'h00;
                FILL_CHECKER: data = i[0] ? 8'h55 : 8'hAA;
                default:      data = 8'($urandom);
            endcase
            push_item(data, 1'b0);
            crc = crc8_next(crc, data, cfg_poly);
        end
        if (corrupt_crc)
            crc ^= 8'($urandom_range(1, 255));
        push_item(crc, 1'b0);
    endtask

    function automatic payload_fill_t pick_fill();
        case ($urandom_range(0, 9))
            0:       return FILL_ONES;
            1:       return FILL_ZEROS;
            2:       return FILL_CHECKER;
            default: return FILL_RANDOM;
        endcase
    endfunction

    // Mostly well-formed channel frames, then other types, bad CRC, other lengths,
    // bad lengths, cut-off frames and line noise
    task automatic push_random_traffic(input int budget);
        int start;
        int sel;
        int len;
        int cut;
        start = items_queued;
        while (items_queued - start < budget) begin
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                push_frame(crsf_pkg::CHANNEL_FRAME_LENGTH, cfg_type, pick_fill(), 1'b0);
            end else if (sel < 63) begin
                push_frame(crsf_pkg::CHANNEL_FRAME_LENGTH, 8'($urandom), FILL_RANDOM, 1'b0);
            end else if (sel < 71) begin
                push_frame(crsf_pkg::CHANNEL_FRAME_LENGTH, cfg_type, FILL_RANDOM, 1'b1);
            end else if (sel < 79) begin
                len = $urandom_range(crsf_pkg::MIN_LEN_BYTE, crsf_pkg::MAX_LEN_BYTE);
                push_frame(len, $urandom_range(0, 1) ? cfg_type : 8'($urandom), FILL_RANDOM,
                           1'b0);
            end else if (sel < 85) begin
                push_item(cfg_sync, 1'b0);
                case ($urandom_range(0, 4))
                    0:       push_item(8'h00, 1'b0);
                    1:       push_item(crsf_pkg::MIN_LEN_BYTE - 8'd1, 1'b0);
                    2:       push_item(crsf_pkg::MAX_LEN_BYTE + 8'd1, 1'b0);
                    3:       push_item(8'hFF, 1'b0);
                    default: push_item(8'($urandom_range(crsf_pkg::MAX_LEN_BYTE + 1, 255)),
                                       1'b0);
                endcase
            end else if (sel < 91) begin
                // cut the frame short, before its CRC byte
                len = $urandom_range(crsf_pkg::MIN_LEN_BYTE, crsf_pkg::MAX_LEN_BYTE);
                cut = $urandom_range(0, len - 1);
                push_item(cfg_sync, 1'b0);
                push_item(8'(len), 1'b0);
                repeat (cut) push_item(8'($urandom), 1'b0);
                push_idle();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) == 0)
                        push_idle();
                    else
                        push_item(8'($urandom), 1'b0);
                end
                if ($urandom_range(0, 3) != 0)
                    push_idle();
            end
            if ($urandom_range(0, 4) == 0)
                push_idle();
        end
    endtask

    task automatic write_register(input crsf_pkg::cfg_idx_t idx, input logic [7:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            crsf_pkg::REG_SYNC_VALUE:         cfg_sync = value;
            crsf_pkg::REG_CHANNEL_FRAME_TYPE: cfg_type = value;
            crsf_pkg::REG_CRC_POLYNOMIAL:     cfg_poly = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] sync, input logic [7:0] ftype,
                              input logic [7:0] poly);
        write_register(crsf_pkg::REG_SYNC_VALUE, sync);
        write_register(crsf_pkg::REG_CHANNEL_FRAME_TYPE, ftype);
        write_register(crsf_pkg::REG_CRC_POLYNOMIAL, poly);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Block the stimulus thread until every transaction is taken and every channel has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (items_accepted != items_queued || expected_channels.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        push_item(8'hFF, 1'b1);
        push_item(8'h00, 1'b0);
        // a sync byte in the length slot is a bad length, not a new start
        push_item(cfg_sync, 1'b0);
        push_item(cfg_sync, 1'b0);
        push_frame(crsf_pkg::CHANNEL_FRAME_LENGTH, cfg_type, FILL_ONES, 1'b0);
        push_item(cfg_sync, 1'b0);
        push_item(crsf_pkg::MIN_LEN_BYTE - 8'd1, 1'b0);
        push_item(cfg_sync, 1'b0);
        push_item(crsf_pkg::MAX_LEN_BYTE + 8'd1, 1'b0);
        push_item(cfg_sync, 1'b0);
        push_item(8'(crsf_pkg::CHANNEL_FRAME_LENGTH), 1'b0);
        push_item(cfg_type, 1'b0);
        repeat (3) push_item(8'($urandom), 1'b0);
        push_idle();
        push_frame(crsf_pkg::MIN_LEN_BYTE, cfg_type, FILL_RANDOM, 1'b0);
        push_frame(crsf_pkg::CHANNEL_FRAME_LENGTH, cfg_type, FILL_ZEROS, 1'b1);
        push_frame(crsf_pkg::CHANNEL_FRAME_LENGTH, cfg_type, FILL_ZEROS, 1'b0);
        wait_drained();

        push_random_traffic(ITEMS_PER_PHASE);
        wait_drained();

        set_config(8'h00, 8'h00, 8'h00);
        push_random_traffic(ITEMS_PER_PHASE);
        wait_drained();

        set_config(8'hFF, 8'hFF, 8'hFF);
        push_random_traffic(ITEMS_PER_PHASE);
        wait_drained();

        set_config($urandom_range(0, 1) ?
                       8'($urandom_range(crsf_pkg::MIN_LEN_BYTE, crsf_pkg::MAX_LEN_BYTE))
                     : 8'($urandom),
                   8'($urandom), 8'($urandom));
        push_random_traffic(ITEMS_PER_PHASE);
        wait_drained();

        // stall the receiver long enough for the frame queue to fill and back up the input
        set_config(crsf_pkg::SYNC_RESET, crsf_pkg::TYPE_RESET, crsf_pkg::POLY_RESET);
        hold_requests++;
        repeat (4) push_frame(crsf_pkg::CHANNEL_FRAME_LENGTH, cfg_type, FILL_RANDOM, 1'b0);
        wait_drained();
        push_random_traffic(ITEMS_PER_PHASE / 2);
        wait_drained();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Sender: bursts of random length, random gaps, some bursts back to back
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_items.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                s_data  <= pending_items.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // Receiver: segments of steady, coin-flip and periodic ready, plus requested long holds
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holds_done != hold_requests) begin
            m_ready <= 1'b0;
            if (hold_count == RX_HOLD_CYCLES - 1) begin
                hold_count = 0;
                holds_done++;
            end else begin
                hold_count++;
            end
        end else begin
            if (rx_seg_left == 0) begin
                rx_mode     = rx_mode_t'($urandom_range(0, 2));
                rx_seg_left = $urandom_range(10, 150);
            end else begin
                rx_seg_left--;
            end
            rx_tick++;
            case (rx_mode)
                RX_STEADY: m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                default:   m_ready <= (rx_tick % 9) < 5;
            endcase
        end
    end

    // Monitor: check returned channels first, then feed accepted bytes to the parser model
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_channels.size() == 0) begin
                    report_mismatch("channel with none pending, index", m_data.channel_index, 0);
                end else begin
                    next_channel = expected_channels.pop_front();
                    if (m_data.channel_index !== next_channel.channel_index)
                        report_mismatch("channel_index", m_data.channel_index,
                                        next_channel.channel_index);
                    if (m_data.channel_value !== next_channel.channel_value)
                        report_mismatch("channel_value", m_data.channel_value,
                                        next_channel.channel_value);
                    if (m_data.last_channel !== next_channel.last_channel)
                        report_mismatch("last_channel", m_data.last_channel,
                                        next_channel.last_channel);
                end
            end
            if (s_valid && s_ready) begin
                items_accepted++;
                decode_byte(s_data);
            end
        end
    end

    // Watchdog: end the run after too long with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
